FILE: hw/rtl/mpi_pkg.sv
// Shared widths, codes and constants of the motion profile interpolator.
`default_nettype none

package mpi_pkg;

   localparam int POS_WIDTH       = 32;
   localparam int TIME_WIDTH      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int PROG_WIDTH      = FRAC_BITS + 1;
   localparam int MODE_WIDTH      = 2;
   localparam int AXES            = 3;
   localparam int AXIS_WIDTH      = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = (POS_WIDTH > TIME_WIDTH) ? POS_WIDTH : TIME_WIDTH;

   localparam int DIFF_WIDTH      = POS_WIDTH + 1;
   localparam int HERM_WIDTH      = PROG_WIDTH + 2;
   localparam int INNER_WIDTH     = PROG_WIDTH + 4;
   localparam int INNER_S_WIDTH   = INNER_WIDTH + 1;
   localparam int MUL_A_WIDTH     = DIFF_WIDTH;
   localparam int MUL_B_WIDTH     = INNER_WIDTH;
   localparam int PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(FRAC_BITS);

   localparam logic [PROG_WIDTH-1:0]    PROG_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PROD_WIDTH-1:0]    PROD_HALF = PROD_WIDTH'(1) << (FRAC_BITS - 1);
   localparam logic [INNER_S_WIDTH-1:0] INNER_TEN_ONE = INNER_S_WIDTH'(10) << FRAC_BITS;

   localparam logic [MODE_WIDTH-1:0] MODE_STEP     = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_LINEAR   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_QUINTIC  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_HERMITE  = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROFILE_MODE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MOVE_DURATION = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_X      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_Y      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_Z      = 3'd4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/mpi_req_if.sv
// Request channel: start or query items with time and current position.
`default_nettype none

interface mpi_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   op;
   logic        [mpi_pkg::TIME_WIDTH-1:0]  now_time;
   logic signed [mpi_pkg::POS_WIDTH-1:0]   cur_x;
   logic signed [mpi_pkg::POS_WIDTH-1:0]   cur_y;
   logic signed [mpi_pkg::POS_WIDTH-1:0]   cur_z;

   modport source (output valid, op, now_time, cur_x, cur_y, cur_z, input ready);
   modport sink   (input valid, op, now_time, cur_x, cur_y, cur_z, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mpi_rsp_if.sv
// Response channel: desired pose, shaped progress and finished flag.
`default_nettype none

interface mpi_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mpi_pkg::POS_WIDTH-1:0]   want_x;
   logic signed [mpi_pkg::POS_WIDTH-1:0]   want_y;
   logic signed [mpi_pkg::POS_WIDTH-1:0]   want_z;
   logic        [mpi_pkg::PROG_WIDTH-1:0]  progress;
   logic                                   finished;

   modport source (output valid, want_x, want_y, want_z, progress, finished, input ready);
   modport sink   (input valid, want_x, want_y, want_z, progress, finished, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mpi_frac_div.sv
// Restoring fraction divider: floor(num * 2^FRAC_BITS / den) for num < den, one bit a cycle.
`default_nettype none

module mpi_frac_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [mpi_pkg::TIME_WIDTH-1:0]     num,
   input  wire logic [mpi_pkg::TIME_WIDTH-1:0]     den,
   output logic                                    done,
   output logic      [mpi_pkg::FRAC_BITS-1:0]      quot
);

   logic                                   run_ff, run_in;
   logic                                   done_ff, done_in;
   logic [mpi_pkg::DIV_COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [mpi_pkg::TIME_WIDTH-1:0]         rem_ff, rem_in;
   logic [mpi_pkg::TIME_WIDTH-1:0]         den_ff, den_in;
   logic [mpi_pkg::FRAC_BITS-1:0]          quot_ff, quot_in;
   logic [mpi_pkg::TIME_WIDTH:0]           shifted;
   logic [mpi_pkg::TIME_WIDTH:0]           reduced;
   logic                                   fits;

   assign shifted = {rem_ff, 1'b0};
   assign reduced = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = '0;
         rem_in   = num;
         den_in   = den;
         quot_in  = '0;
      end else if (run_ff) begin
         rem_in   = fits ? reduced[mpi_pkg::TIME_WIDTH-1:0] : shifted[mpi_pkg::TIME_WIDTH-1:0];
         quot_in  = {quot_ff[mpi_pkg::FRAC_BITS-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == mpi_pkg::DIV_COUNT_WIDTH'(mpi_pkg::FRAC_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quot_ff  <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/motion_profile_interpolator.sv
// Motion profile interpolator top level: sequencer, shared multiplier and registers.
// A start item (op 0) stores the current position and time as the move origin and
// gives no response. A query item (op 1) runs the sequencer from transfer to
// response: a jump (zero duration or step mode) skips the divider and the shaping steps; a
// shaped move uses the 16-step restoring divider for progress and one 33x21 multiplier that
// serves the t^2, t^3 and quintic terms and then each of the three axes in turn. Ready
// is high only while the sequencer is idle; a finished response waits in the output
// register while the next item is transferred.
`default_nettype none

module motion_profile_interpolator (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   mpi_req_if.sink                                      req_chan,
   mpi_rsp_if.source                                    rsp_chan,
   input  wire logic                                    csr_write_en,
   input  wire logic [mpi_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [mpi_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PREP  = 4'd1;
   localparam logic [3:0] ST_CLASS = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_M_T2  = 4'd4;
   localparam logic [3:0] ST_T2    = 4'd5;
   localparam logic [3:0] ST_M_T3  = 4'd6;
   localparam logic [3:0] ST_T3    = 4'd7;
   localparam logic [3:0] ST_SHAPE = 4'd8;
   localparam logic [3:0] ST_M_Q   = 4'd9;
   localparam logic [3:0] ST_Q     = 4'd10;
   localparam logic [3:0] ST_DIFF  = 4'd11;
   localparam logic [3:0] ST_M_AX  = 4'd12;
   localparam logic [3:0] ST_RND   = 4'd13;
   localparam logic [3:0] ST_AX    = 4'd14;
   localparam logic [3:0] ST_DONE  = 4'd15;

   localparam int PW = mpi_pkg::POS_WIDTH;
   localparam int TW = mpi_pkg::TIME_WIDTH;
   localparam int GW = mpi_pkg::PROG_WIDTH;
   localparam int DW = mpi_pkg::DIFF_WIDTH;

   logic [3:0]                             state_ff, state_in;
   logic [mpi_pkg::MODE_WIDTH-1:0]         mode_ff, mode_in;
   logic [TW-1:0]                          duration_ff, duration_in;
   logic signed [PW-1:0]                   target_ff [0:mpi_pkg::AXES-1];
   logic signed [PW-1:0]                   target_in [0:mpi_pkg::AXES-1];
   logic signed [PW-1:0]                   origin_ff [0:mpi_pkg::AXES-1];
   logic signed [PW-1:0]                   origin_in [0:mpi_pkg::AXES-1];
   logic [TW-1:0]                          origin_time_ff, origin_time_in;
   logic [TW-1:0]                          now_ff, now_in;
   logic [TW-1:0]                          elapsed_ff, elapsed_in;
   logic                                   before_ff, before_in;
   logic                                   fin_ff, fin_in;
   logic [GW-1:0]                          t_ff, t_in;
   logic [GW-1:0]                          t2_ff, t2_in;
   logic [GW-1:0]                          t3_ff, t3_in;
   logic [mpi_pkg::INNER_WIDTH-1:0]        inner_ff, inner_in;
   logic [GW-1:0]                          s_ff, s_in;
   logic [mpi_pkg::PROD_WIDTH-1:0]         prod_ff, prod_in;
   logic [DW-1:0]                          abs_ff, abs_in;
   logic                                   neg_ff, neg_in;
   logic [DW-1:0]                          q_ff, q_in;
   logic [mpi_pkg::AXIS_WIDTH-1:0]         axis_ff, axis_in;
   logic signed [PW-1:0]                   want_ff [0:mpi_pkg::AXES-1];
   logic signed [PW-1:0]                   want_in [0:mpi_pkg::AXES-1];
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [PW-1:0]                   rsp_x_ff, rsp_x_in;
   logic signed [PW-1:0]                   rsp_y_ff, rsp_y_in;
   logic signed [PW-1:0]                   rsp_z_ff, rsp_z_in;
   logic [GW-1:0]                          rsp_prog_ff, rsp_prog_in;
   logic                                   rsp_fin_ff, rsp_fin_in;

   logic                                   div_start;
   logic                                   div_done;
   logic [mpi_pkg::FRAC_BITS-1:0]          div_quot;

   logic [TW:0]                            time_diff;
   logic [TW:0]                            dur_cmp;
   logic                                   jump;
   logic [mpi_pkg::MUL_A_WIDTH-1:0]        mul_a;
   logic [mpi_pkg::MUL_B_WIDTH-1:0]        mul_b;
   logic [mpi_pkg::PROD_WIDTH-1:0]         mul_prod;
   logic [mpi_pkg::PROD_WIDTH-1:0]         prod_rnd_sum;
   logic [mpi_pkg::PROD_WIDTH-1:0]         prod_rnd;
   logic [mpi_pkg::HERM_WIDTH-1:0]         herm;
   logic [mpi_pkg::INNER_S_WIDTH-1:0]      inner_raw;
   logic signed [PW-1:0]                   org_sel;
   logic signed [PW-1:0]                   tgt_sel;
   logic [DW-1:0]                          org_ext;
   logic [DW-1:0]                          tgt_ext;
   logic [DW-1:0]                          diff_up;
   logic [DW-1:0]                          diff_down;
   logic [DW-1:0]                          want_sum;
   logic                                   rsp_load;

   mpi_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (elapsed_ff),
      .den   (duration_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign time_diff = {1'b0, now_ff} - {1'b0, origin_time_ff};
   assign dur_cmp   = {1'b0, duration_ff} - {1'b0, elapsed_ff};
   assign jump      = (duration_ff == '0) || (mode_ff == mpi_pkg::MODE_STEP);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M_T2: begin
            mul_a = mpi_pkg::MUL_A_WIDTH'(t_ff);
            mul_b = mpi_pkg::MUL_B_WIDTH'(t_ff);
         end
         ST_M_T3: begin
            mul_a = mpi_pkg::MUL_A_WIDTH'(t2_ff);
            mul_b = mpi_pkg::MUL_B_WIDTH'(t_ff);
         end
         ST_M_Q: begin
            mul_a = mpi_pkg::MUL_A_WIDTH'(t3_ff);
            mul_b = inner_ff;
         end
         ST_M_AX: begin
            mul_a = abs_ff;
            mul_b = mpi_pkg::MUL_B_WIDTH'(s_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod     = mul_a * mul_b;
   assign prod_rnd_sum = prod_ff + mpi_pkg::PROD_HALF;
   assign prod_rnd     = prod_rnd_sum >> mpi_pkg::FRAC_BITS;

   assign herm = mpi_pkg::HERM_WIDTH'({t2_ff, 1'b0}) + mpi_pkg::HERM_WIDTH'(t2_ff)
               - mpi_pkg::HERM_WIDTH'({t3_ff, 1'b0});

   assign inner_raw = mpi_pkg::INNER_S_WIDTH'({t2_ff, 2'b0})
                    + mpi_pkg::INNER_S_WIDTH'({t2_ff, 1'b0})
                    + mpi_pkg::INNER_TEN_ONE
                    + mpi_pkg::INNER_S_WIDTH'(t_ff)
                    - mpi_pkg::INNER_S_WIDTH'({t_ff, 4'b0});

   assign org_sel   = origin_ff[axis_ff];
   assign tgt_sel   = target_ff[axis_ff];
   assign org_ext   = {org_sel[PW-1], org_sel};
   assign tgt_ext   = {tgt_sel[PW-1], tgt_sel};
   assign diff_up   = tgt_ext - org_ext;
   assign diff_down = org_ext - tgt_ext;
   assign want_sum  = neg_ff ? (org_ext - q_ff) : (org_ext + q_ff);

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      duration_in    = duration_ff;
      target_in      = target_ff;
      origin_in      = origin_ff;
      origin_time_in = origin_time_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      before_in      = before_ff;
      fin_in         = fin_ff;
      t_in           = t_ff;
      t2_in          = t2_ff;
      t3_in          = t3_ff;
      inner_in       = inner_ff;
      s_in           = s_ff;
      prod_in        = prod_ff;
      abs_in         = abs_ff;
      neg_in         = neg_ff;
      q_in           = q_ff;
      axis_in        = axis_ff;
      want_in        = want_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_z_in       = rsp_z_ff;
      rsp_prog_in    = rsp_prog_ff;
      rsp_fin_in     = rsp_fin_ff;
      div_start      = 1'b0;
      rsp_load       = 1'b0;

      if (csr_write_en) begin
         case (csr_index)
            mpi_pkg::REG_PROFILE_MODE:  mode_in      = csr_wdata[mpi_pkg::MODE_WIDTH-1:0];
            mpi_pkg::REG_MOVE_DURATION: duration_in  = csr_wdata[TW-1:0];
            mpi_pkg::REG_TARGET_X:      target_in[0] = $signed(csr_wdata[PW-1:0]);
            mpi_pkg::REG_TARGET_Y:      target_in[1] = $signed(csr_wdata[PW-1:0]);
            mpi_pkg::REG_TARGET_Z:      target_in[2] = $signed(csr_wdata[PW-1:0]);
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.op == mpi_pkg::OP_START) begin
                  origin_in[0]   = req_chan.cur_x;
                  origin_in[1]   = req_chan.cur_y;
                  origin_in[2]   = req_chan.cur_z;
                  origin_time_in = req_chan.now_time;
               end else begin
                  now_in   = req_chan.now_time;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            elapsed_in = time_diff[TW-1:0];
            before_in  = time_diff[TW];
            state_in   = ST_CLASS;
         end
         ST_CLASS: begin
            fin_in  = !before_ff && dur_cmp[TW];
            axis_in = '0;
            if (jump) begin
               s_in     = mpi_pkg::PROG_ONE;
               state_in = ST_DIFF;
            end else if (before_ff) begin
               t_in     = '0;
               state_in = ST_M_T2;
            end else if (dur_cmp[TW] || (dur_cmp == '0)) begin
               t_in     = mpi_pkg::PROG_ONE;
               state_in = ST_M_T2;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               t_in     = {1'b0, div_quot};
               state_in = ST_M_T2;
            end
         end
         ST_M_T2: begin
            prod_in  = mul_prod;
            state_in = ST_T2;
         end
         ST_T2: begin
            t2_in    = prod_rnd[GW-1:0];
            state_in = ST_M_T3;
         end
         ST_M_T3: begin
            prod_in  = mul_prod;
            state_in = ST_T3;
         end
         ST_T3: begin
            t3_in    = prod_rnd[GW-1:0];
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            state_in = ST_DIFF;
            case (mode_ff)
               mpi_pkg::MODE_LINEAR: s_in = t_ff;
               mpi_pkg::MODE_HERMITE: begin
                  if (herm[mpi_pkg::HERM_WIDTH-1]) begin
                     s_in = '0;
                  end else if (herm > mpi_pkg::HERM_WIDTH'(mpi_pkg::PROG_ONE)) begin
                     s_in = mpi_pkg::PROG_ONE;
                  end else begin
                     s_in = herm[GW-1:0];
                  end
               end
               mpi_pkg::MODE_QUINTIC: begin
                  inner_in = inner_raw[mpi_pkg::INNER_S_WIDTH-1] ? '0
                           : inner_raw[mpi_pkg::INNER_WIDTH-1:0];
                  state_in = ST_M_Q;
               end
               default: s_in = mpi_pkg::PROG_ONE;
            endcase
         end
         ST_M_Q: begin
            prod_in  = mul_prod;
            state_in = ST_Q;
         end
         ST_Q: begin
            s_in     = (prod_rnd > mpi_pkg::PROD_WIDTH'(mpi_pkg::PROG_ONE)) ? mpi_pkg::PROG_ONE
                     : prod_rnd[GW-1:0];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in   = diff_up[DW-1];
            abs_in   = diff_up[DW-1] ? diff_down : diff_up;
            state_in = ST_M_AX;
         end
         ST_M_AX: begin
            prod_in  = mul_prod;
            state_in = ST_RND;
         end
         ST_RND: begin
            q_in     = prod_rnd[DW-1:0];
            state_in = ST_AX;
         end
         ST_AX: begin
            want_in[axis_ff] = $signed(want_sum[PW-1:0]);
            if (axis_ff == mpi_pkg::AXIS_WIDTH'(mpi_pkg::AXES - 1)) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load    = 1'b1;
               rsp_x_in    = want_ff[0];
               rsp_y_in    = want_ff[1];
               rsp_z_in    = want_ff[2];
               rsp_prog_in = s_ff;
               rsp_fin_in  = fin_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         mode_ff        <= '0;
         duration_ff    <= '0;
         target_ff      <= '{default: '0};
         origin_ff      <= '{default: '0};
         origin_time_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         mode_ff        <= mode_in;
         duration_ff    <= duration_in;
         target_ff      <= target_in;
         origin_ff      <= origin_in;
         origin_time_ff <= origin_time_in;
      end
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      before_ff   <= before_in;
      fin_ff      <= fin_in;
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      inner_ff    <= inner_in;
      s_ff        <= s_in;
      prod_ff     <= prod_in;
      abs_ff      <= abs_in;
      neg_ff      <= neg_in;
      q_ff        <= q_in;
      axis_ff     <= axis_in;
      want_ff     <= want_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_prog_ff <= rsp_prog_in;
      rsp_fin_ff  <= rsp_fin_in;
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.want_x   = rsp_x_ff;
   assign rsp_chan.want_y   = rsp_y_ff;
   assign rsp_chan.want_z   = rsp_z_ff;
   assign rsp_chan.progress = rsp_prog_ff;
   assign rsp_chan.finished = rsp_fin_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside the done step");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished while sequencer not waiting on it");

   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.op == mpi_pkg::OP_START)
      |=> state_ff == ST_IDLE)
      else $error("start transfer left the sequencer busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_prog_ff <= mpi_pkg::PROG_ONE)
      else $error("shaped progress above one");

endmodule

`default_nettype wire
